// ----- sv/lz_window_decompressor_macros.svh -----
// Assertion macros shared by the LZ window decompressor modules.
// Depends on nothing; the using module must have i_clk and i_rst_n in scope.
`ifndef LZ_WINDOW_DECOMPRESSOR_MACROS_SVH
`define LZ_WINDOW_DECOMPRESSOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LZWD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LZWD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/lzwd_pkg.sv -----
// Shared constants and types for the LZ window decompressor.
// Used by lzwd_ring and lz_window_decompressor; depends on nothing.
`default_nettype none

package lzwd_pkg;

    // History window; the depth is a power of two so ring addresses wrap naturally.
    localparam int LZWD_WINDOW_DEPTH = 32768;
    localparam int LZWD_ADDR_W       = $clog2(LZWD_WINDOW_DEPTH);

    localparam int LZWD_WORD_W  = 16;
    localparam int LZWD_TOTAL_W = 32;

    // Reference format: high part scaled by 128, length base of five plus one.
    localparam logic [LZWD_WORD_W-1:0] LZWD_MARKER = 16'h7fff;
    localparam int LZWD_HIGH_SHIFT = $clog2(128);
    localparam int LZWD_BASE_LEN   = 5;
    localparam int LZWD_DIST_W     = LZWD_WORD_W + LZWD_HIGH_SHIFT + 1;
    localparam int LZWD_CNT_W      = 3;

    // Marker run saturates at three, which means a reference is pending.
    localparam logic [1:0] LZWD_RUN_FULL = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RUN,
        S_RD,
        S_WR
    } t_lzwd_state;

endpackage

`default_nettype wire

// ----- sv/lz_window_decompressor.sv -----
// LZ window decompressor top level: word sequencer, output register and history ring.
// Depends on lzwd_pkg, lzwd_ring and lz_window_decompressor_macros.svh.
//
//  Channel | Dir | Beat content (tdata from bit 0 up)            | tlast        | tuser
//  s_axis  | in  | in_word[15:0]                                  | last_in      | -
//  m_axis  | out | out_word[15:0], words_total[47:16]             | end_of_run   | bad_reference
//
// An input beat is taken while the sequencer is idle; it then runs alone until the beat's
// results are all queued, with s_axis not ready. Literal and marker words are each emitted
// from the run state, a copied word passes dispatch, ring read, then emit, a reference
// first passes the distance check, and a closing step ends each beat. The single ring
// port pair and the one output register make the sequencer handle one word at a time.
// Reset is synchronous; the ring needs no clearing pass, so s_axis is ready right after
// reset. A stalled m_axis holds its beat and the sequencer waits on it.
`default_nettype none

`include "lz_window_decompressor_macros.svh"

module lz_window_decompressor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // in_word[15:0]
    input  wire logic        i_s_axis_tlast,
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output      logic [47:0] o_m_axis_tdata,   // out_word[15:0], words_total[47:16]
    output      logic        o_m_axis_tlast,
    output      logic        o_m_axis_tuser    // bad_reference[0]
);
    import lzwd_pkg::*;

    // Sequencer state and plan of the beat in flight.
    t_lzwd_state r_state, n_state;
    logic [1:0]              r_pre, n_pre;
    logic                    r_lit, n_lit;
    logic [LZWD_CNT_W-1:0]   r_cnt, n_cnt;
    logic                    r_err, n_err;
    logic                    r_clear, n_clear;
    logic [LZWD_WORD_W-1:0]  r_word, n_word;
    logic [LZWD_DIST_W-1:0]  r_dist, n_dist;
    logic [LZWD_ADDR_W-1:0]  r_src, n_src;

    // Stream state.
    logic [LZWD_ADDR_W-1:0]  r_wp, n_wp;
    logic [LZWD_TOTAL_W-1:0] r_produced, n_produced;
    logic [1:0]              r_run, n_run;
    logic                    r_await, n_await;
    logic [LZWD_WORD_W-1:0]  r_high, n_high;

    // Output register.
    logic                    r_ovalid, n_ovalid;
    logic [LZWD_WORD_W-1:0]  r_oword, n_oword;
    logic [LZWD_TOTAL_W-1:0] r_ototal, n_ototal;
    logic                    r_olast, n_olast;
    logic                    r_oerr, n_oerr;

    // Emit request and ring access.
    logic                    emit, emit_err, emit_last;
    logic [LZWD_WORD_W-1:0]  emit_val;
    logic                    out_free, s_accept, ring_re;
    logic [LZWD_WORD_W-1:0]  ring_rdata;
    logic [LZWD_TOTAL_W-1:0] total_inc;
    logic [1:0]              run_inc;
    logic                    is_marker;

    lzwd_ring u_ring (
        .i_clk   (i_clk),
        .i_we    (emit && !emit_err),
        .i_waddr (r_wp),
        .i_wdata (emit_val),
        .i_re    (ring_re),
        .i_raddr (r_src),
        .o_rdata (ring_rdata)
    );

    assign out_free        = !r_ovalid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign total_inc       = (r_produced == '1) ? r_produced : r_produced + 1'b1;
    assign is_marker       = (i_s_axis_tdata == LZWD_MARKER);
    assign run_inc         = r_run + 2'd1;

    // Next state: beat planning, distance check and one emission per cycle while the output register is free.
    always_comb begin
        n_state    = r_state;
        n_pre      = r_pre;
        n_lit      = r_lit;
        n_cnt      = r_cnt;
        n_err      = r_err;
        n_clear    = r_clear;
        n_word     = r_word;
        n_dist     = r_dist;
        n_src      = r_src;
        n_wp       = r_wp;
        n_produced = r_produced;
        n_run      = r_run;
        n_await    = r_await;
        n_high     = r_high;
        emit       = 1'b0;
        emit_err   = 1'b0;
        emit_last  = 1'b0;
        emit_val   = '0;
        ring_re    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_word  = i_s_axis_tdata;
                    n_clear = i_s_axis_tlast;
                    n_pre   = 2'd0;
                    n_lit   = 1'b0;
                    n_cnt   = '0;
                    n_err   = 1'b0;
                    n_dist  = LZWD_DIST_W'({r_high, {LZWD_HIGH_SHIFT{1'b0}}})
                            + LZWD_DIST_W'(i_s_axis_tdata[LZWD_WORD_W-1:1])
                            + LZWD_DIST_W'(1);
                    n_state = S_RUN;
                    if (r_await) begin
                        // Low part of a reference: length is six or seven.
                        n_cnt   = LZWD_CNT_W'(LZWD_BASE_LEN + 1) + LZWD_CNT_W'(i_s_axis_tdata[0]);
                        n_await = 1'b0;
                        n_run   = 2'd0;
                        n_state = S_CHECK;
                    end else if (is_marker) begin
                        if (r_run == LZWD_RUN_FULL) begin
                            n_pre = 2'd1;
                            n_err = i_s_axis_tlast;
                        end else begin
                            n_run = run_inc;
                            if (i_s_axis_tlast) begin
                                // Three markers with the stream ending: truncated reference.
                                n_err = (run_inc == LZWD_RUN_FULL);
                                n_pre = (run_inc == LZWD_RUN_FULL) ? 2'd0 : run_inc;
                            end
                        end
                    end else if (r_run == LZWD_RUN_FULL) begin
                        n_high  = i_s_axis_tdata;
                        n_await = 1'b1;
                        n_run   = 2'd0;
                        n_err   = i_s_axis_tlast;
                    end else begin
                        // Partial marker run flushes as literals ahead of the word.
                        n_pre = r_run;
                        n_lit = 1'b1;
                        n_run = 2'd0;
                    end
                    if (i_s_axis_tlast) begin
                        n_run   = 2'd0;
                        n_await = 1'b0;
                        n_high  = '0;
                    end
                end
            end

            S_CHECK: begin
                // Distance must lie within the words produced and within the window.
                if ((LZWD_TOTAL_W'(r_dist) > r_produced)
                        || (r_dist > LZWD_DIST_W'(LZWD_WINDOW_DEPTH))) begin
                    n_cnt = '0;
                    n_err = 1'b1;
                end
                n_src   = r_wp - r_dist[LZWD_ADDR_W-1:0];
                n_state = S_RUN;
            end

            S_RUN: begin
                priority if (r_pre != 2'd0) begin
                    if (out_free) begin
                        emit      = 1'b1;
                        emit_val  = LZWD_MARKER;
                        emit_last = (r_pre == 2'd1) && !r_lit && (r_cnt == '0) && !r_err;
                        n_pre     = r_pre - 2'd1;
                    end
                end else if (r_lit) begin
                    if (out_free) begin
                        emit      = 1'b1;
                        emit_val  = r_word;
                        emit_last = (r_cnt == '0) && !r_err;
                        n_lit     = 1'b0;
                    end
                end else if (r_cnt != '0) begin
                    n_state = S_RD;
                end else if (r_err) begin
                    if (out_free) begin
                        emit      = 1'b1;
                        emit_err  = 1'b1;
                        emit_last = 1'b1;
                        n_err     = 1'b0;
                    end
                end else begin
                    // Beat finished; an end of stream restarts the stream state.
                    if (r_clear) begin
                        n_wp       = '0;
                        n_produced = '0;
                    end
                    n_state = S_IDLE;
                end
            end

            S_RD: begin
                ring_re = 1'b1;
                n_state = S_WR;
            end

            S_WR: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_val  = ring_rdata;
                    emit_last = (r_cnt == LZWD_CNT_W'(1)) && !r_err;
                    n_cnt     = r_cnt - 1'b1;
                    n_src     = r_src + 1'b1;
                    n_state   = S_RUN;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A decoded word advances the ring and the running count.
        if (emit && !emit_err) begin
            n_wp       = r_wp + 1'b1;
            n_produced = total_inc;
        end
    end

    // Output register loads on emit and drains on a taken beat.
    always_comb begin
        n_ovalid = r_ovalid;
        n_oword  = r_oword;
        n_ototal = r_ototal;
        n_olast  = r_olast;
        n_oerr   = r_oerr;
        if (emit) begin
            n_ovalid = 1'b1;
            n_oword  = emit_err ? '0 : emit_val;
            n_ototal = emit_err ? r_produced : total_inc;
            n_olast  = emit_last;
            n_oerr   = emit_err;
        end else if (i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pre      <= 2'd0;
            r_lit      <= 1'b0;
            r_cnt      <= '0;
            r_err      <= 1'b0;
            r_clear    <= 1'b0;
            r_wp       <= '0;
            r_produced <= '0;
            r_run      <= 2'd0;
            r_await    <= 1'b0;
            r_high     <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pre      <= n_pre;
            r_lit      <= n_lit;
            r_cnt      <= n_cnt;
            r_err      <= n_err;
            r_clear    <= n_clear;
            r_wp       <= n_wp;
            r_produced <= n_produced;
            r_run      <= n_run;
            r_await    <= n_await;
            r_high     <= n_high;
            r_ovalid   <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_dist   <= n_dist;
        r_src    <= n_src;
        r_oword  <= n_oword;
        r_ototal <= n_ototal;
        r_olast  <= n_olast;
        r_oerr   <= n_oerr;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_ototal, r_oword};
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_oerr;

    // Checks on the sequencer and the output beats.
    `LZWD_ASSERT_NEXT(a_read_then_emit, r_state == S_RD, r_state == S_WR, "ring read not followed by emit")
    `LZWD_ASSERT_NOW(a_idle_no_work, r_state == S_IDLE, (r_pre == 2'd0) && !r_lit && (r_cnt == '0) && !r_err, "idle with work pending")
    `LZWD_ASSERT_NOW(a_err_word_zero, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata[15:0] == 16'h0000, "error beat carries data")
    `LZWD_ASSERT_NEXT(a_count_steps, emit && !emit_err && (r_produced != '1), r_produced == $past(r_produced) + 1'b1, "word count did not advance")

endmodule

`default_nettype wire

// ----- sv/lzwd_ring.sv -----
// History ring of the LZ window decompressor: one write port, one registered read port.
// Depends on lzwd_pkg.
`default_nettype none

module lzwd_ring (
    input  wire logic                            i_clk,
    input  wire logic                            i_we,
    input  wire logic [lzwd_pkg::LZWD_ADDR_W-1:0] i_waddr,
    input  wire logic [lzwd_pkg::LZWD_WORD_W-1:0] i_wdata,
    input  wire logic                            i_re,
    input  wire logic [lzwd_pkg::LZWD_ADDR_W-1:0] i_raddr,
    output      logic [lzwd_pkg::LZWD_WORD_W-1:0] o_rdata
);
    import lzwd_pkg::*;

    logic [LZWD_WORD_W-1:0] r_mem [LZWD_WINDOW_DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data register holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
